// ----- sv/rbp_pkg.sv -----
// ============================================================================
// Rice bit packer package
// Shared payload types, operation codes, state encoding and the command and
// status groups that join the controller to the datapath.
// ============================================================================
package rbp_pkg;

    // Largest unary run accepted by default.
    localparam int MAX_QUOTIENT_DEF = 255;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_ENCODE = 2'd0;
    localparam logic [1:0] FUNC_WORD   = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] residual;
        logic [3:0]         rice_k;
        logic [15:0]        word_value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENC,
        ST_WORD_PAD,
        ST_WORD_HI,
        ST_WORD_LO,
        ST_FLUSH,
        ST_ERR
    } state_t;

    // Source of a byte that is emitted outside of the encode walk.
    typedef enum logic [1:0] {
        SRC_FRAG,
        SRC_WORD_HI,
        SRC_WORD_LO,
        SRC_ZERO
    } emit_src_t;

    typedef struct packed {
        logic      load;
        logic      enc_step;
        logic      emit;
        emit_src_t emit_src;
        logic      emit_last;
        logic      emit_err;
        logic      clear_frag;
    } cmd_t;

    typedef struct packed {
        logic over_limit;
        logic frag_empty;
        logic step_complete;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/rbp_ctrl.sv -----
// ============================================================================
// Rice bit packer controller
// Sequences one item at a time: encode walk, aligned word, flush and the
// quotient overflow report. Drives datapath commands from its status.
// ============================================================================
module rbp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic [1:0]     func,
    input  rbp_pkg::sts_t  sts,
    output logic           item_ready,
    output rbp_pkg::cmd_t  cmd
);
    import rbp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = item_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_ENCODE)
                    begin
                        state_next = sts.over_limit ? ST_ERR : ST_ENC;
                    end
                    else if (func == FUNC_WORD)
                    begin
                        state_next = ST_WORD_PAD;
                    end
                    else if (func == FUNC_FLUSH && !sts.frag_empty)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_ENC:
            begin
                if ((!sts.step_complete || sts.out_free) && sts.rem_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WORD_PAD:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_WORD_HI;
                end
            end
            ST_WORD_HI:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_WORD_LO;
                end
            end
            ST_WORD_LO, ST_FLUSH, ST_ERR:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready     = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.emit_src   = SRC_FRAG;
        cmd.load       = accept;
        case (state_reg)
            ST_ENC:
            begin
                cmd.enc_step = !sts.step_complete || sts.out_free;
            end
            ST_WORD_PAD:
            begin
                cmd.emit       = sts.out_free;
                cmd.emit_src   = SRC_FRAG;
                cmd.clear_frag = sts.out_free;
            end
            ST_WORD_HI:
            begin
                cmd.emit     = sts.out_free;
                cmd.emit_src = SRC_WORD_HI;
            end
            ST_WORD_LO:
            begin
                cmd.emit      = sts.out_free;
                cmd.emit_src  = SRC_WORD_LO;
                cmd.emit_last = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.emit       = sts.out_free;
                cmd.emit_src   = SRC_FRAG;
                cmd.emit_last  = 1'b1;
                cmd.clear_frag = sts.out_free;
            end
            ST_ERR:
            begin
                cmd.emit      = sts.out_free;
                cmd.emit_src  = SRC_ZERO;
                cmd.emit_last = 1'b1;
                cmd.emit_err  = 1'b1;
            end
            default:
            begin
                cmd.enc_step = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/rbp_datapath.sv -----
// ============================================================================
// Rice bit packer datapath
// Holds the partial byte, the pending zero run and remainder bits, and the
// output register. One encode step fills the partial byte as far as it goes.
// ============================================================================
module rbp_datapath #(
    parameter int MAX_QUOTIENT = rbp_pkg::MAX_QUOTIENT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rbp_pkg::item_t   item,
    input  rbp_pkg::cmd_t    cmd,
    output rbp_pkg::sts_t    sts,
    output logic             result_valid,
    input  logic             result_ready,
    output rbp_pkg::result_t result
);
    import rbp_pkg::*;

    localparam int QB = $clog2(MAX_QUOTIENT + 1);
    localparam int QW = (QB > 4) ? QB : 4;
    localparam int RW = $clog2(MAX_QUOTIENT + 18);

    logic [7:0]    frag_reg, frag_next;
    logic [2:0]    fill_reg, fill_next;
    logic [QW-1:0] zrem_reg, zrem_next;
    logic [15:0]   tail_reg, tail_next;
    logic [4:0]    tlen_reg, tlen_next;
    logic [15:0]   word_reg;
    logic          result_valid_reg, result_valid_next;
    result_t       result_reg, result_next;

    // Operand decode of the incoming item.
    logic [15:0]   zz;
    logic [15:0]   qq;
    logic [15:0]   zmask;

    // Encode step.
    logic [3:0]    space;
    logic          zeros_full;
    logic [2:0]    zl;
    logic [3:0]    avail;
    logic [4:0]    take;
    logic [2:0]    pos;
    logic [23:0]   shifted;
    logic [3:0]    total;
    logic [7:0]    step_byte;
    logic          step_complete;
    logic [QW-1:0] zrem_step;
    logic [15:0]   tail_step;
    logic [4:0]    tlen_step;
    logic [2:0]    fill_step;
    logic [RW-1:0] rem_after;
    logic          enc_last;
    logic          out_free;
    logic          out_load;

    always_comb
    begin
        zz    = {item.residual[14:0], 1'b0} ^ {16{item.residual[15]}};
        qq    = zz >> item.rice_k;
        zmask = zz & ~(16'hffff << item.rice_k);
    end

    always_comb
    begin
        space      = 4'd8 - {1'b0, fill_reg};
        zeros_full = (zrem_reg >= QW'(space));
        zl         = zrem_reg[2:0];
        avail      = space - {1'b0, zl};
        take       = ({1'b0, avail} < tlen_reg) ? {1'b0, avail} : tlen_reg;
        pos        = fill_reg + zl;
        shifted    = {8'd0, tail_reg} << pos;
        total      = {1'b0, pos} + take[3:0];
        if (zeros_full)
        begin
            step_byte     = frag_reg;
            step_complete = 1'b1;
            zrem_step     = zrem_reg - QW'(space);
            tail_step     = tail_reg;
            tlen_step     = tlen_reg;
            fill_step     = 3'd0;
        end
        else
        begin
            step_byte     = frag_reg | shifted[7:0];
            step_complete = total[3];
            zrem_step     = '0;
            tail_step     = tail_reg >> take;
            tlen_step     = tlen_reg - take;
            fill_step     = total[2:0];
        end
        rem_after = RW'(zrem_step) + RW'(tlen_step);
        enc_last  = (rem_after < RW'(8));
    end

    assign out_free = !result_valid_reg || result_ready;
    assign out_load = cmd.emit || (cmd.enc_step && step_complete);

    always_comb
    begin
        frag_next = frag_reg;
        fill_next = fill_reg;
        zrem_next = zrem_reg;
        tail_next = tail_reg;
        tlen_next = tlen_reg;
        if (cmd.load)
        begin
            zrem_next = qq[QW-1:0];
            tail_next = {zmask[14:0], 1'b1};
            tlen_next = {1'b0, item.rice_k} + 5'd1;
        end
        else if (cmd.enc_step)
        begin
            zrem_next = zrem_step;
            tail_next = tail_step;
            tlen_next = tlen_step;
            frag_next = step_complete ? 8'd0 : step_byte;
            fill_next = step_complete ? 3'd0 : fill_step;
        end
        if (cmd.clear_frag)
        begin
            frag_next = 8'd0;
            fill_next = 3'd0;
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.enc_step)
        begin
            result_next.out_byte = step_byte;
            result_next.last     = enc_last;
            result_next.error    = 1'b0;
        end
        else
        begin
            case (cmd.emit_src)
                SRC_FRAG:    result_next.out_byte = frag_reg;
                SRC_WORD_HI: result_next.out_byte = word_reg[15:8];
                SRC_WORD_LO: result_next.out_byte = word_reg[7:0];
                SRC_ZERO:    result_next.out_byte = 8'd0;
                default:     result_next.out_byte = 8'd0;
            endcase
            result_next.last  = cmd.emit_last;
            result_next.error = cmd.emit_err;
        end
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && !result_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_reg         <= 8'd0;
            fill_reg         <= 3'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            frag_reg         <= frag_next;
            fill_reg         <= fill_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zrem_reg <= zrem_next;
        tail_reg <= tail_next;
        tlen_reg <= tlen_next;
        if (cmd.load)
        begin
            word_reg <= item.word_value;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        sts.over_limit    = (qq > 16'(MAX_QUOTIENT));
        sts.frag_empty    = (fill_reg == 3'd0);
        sts.step_complete = step_complete;
        sts.rem_zero      = (rem_after == '0);
        sts.out_free      = out_free;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sv/rice_bit_packer_unit.sv -----
// ============================================================================
// Rice bit packer unit
// Rice encoder that packs code bits LSB first into bytes, with aligned word
// insertion and a flush of the partial byte.
// ============================================================================
// Usage: items arrive on item_valid/item_ready with the item struct; each
// output byte leaves as one beat on result_valid/result_ready, and the last
// beat caused by an item carries last. An encode item writes its unary zero
// run, a one and rice_k remainder bits; a word item pads to a byte boundary
// (a whole zero byte if already aligned) and sends two big endian bytes; a
// flush item sends the partial byte if there is one. A quotient above
// MAX_QUOTIENT gives a single beat with error set and leaves the state alone.
// Timing: the block takes one item at a time. Beats are registered: each is
// loaded into the output register from a controller state entered after the
// item's acceptance. An encode item occupies the controller for acceptance
// and then one datapath step after another, where a step completes one byte
// or absorbs the tail into the partial byte. A word item walks the pad,
// high and low byte states, a flush or an error report one state, and a
// flush with nothing to send or the unused code never leaves idle. The next
// item is accepted while the final beat of the previous one still waits in
// the output register. When the receiver stalls, the output register holds
// its beat and the controller waits. Reset clears the partial byte, the
// controller and the output valid flag.
// ============================================================================
module rice_bit_packer_unit #(
    parameter int MAX_QUOTIENT = rbp_pkg::MAX_QUOTIENT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  rbp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output rbp_pkg::result_t result
);
    import rbp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: one state machine that walks each item through its beats.
    rbp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .func       (item.func),
        .sts        (sts),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    // Datapath: bit packing state, operand registers and output register.
    rbp_datapath #(
        .MAX_QUOTIENT (MAX_QUOTIENT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // An error beat is always the only and final beat of its item, and zero.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error |-> result.last && (result.out_byte == 8'd0))
        else $error("error beat without last or with nonzero byte");

    // A word item always keeps the controller busy after acceptance.
    a_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.func == FUNC_WORD) |=> !item_ready)
        else $error("word item did not occupy the controller");

    // An oversized quotient must lead to the error report state.
    a_over_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.func == FUNC_ENCODE) && sts.over_limit
        |=> !item_ready)
        else $error("quotient overflow was not reported");

endmodule
